// ===== design/dmt_pkg.sv =====
package dmt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int RAD_W = 24;
	localparam int COORD_W = 32;
	localparam int SQ_W = 2 * RAD_W;
	localparam int ADDR_W = 3;

	// result actions
	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_MERGE = 2'd1;
	localparam logic [1:0] ACT_DROP = 2'd2;

	// register index (address bit 2)
	localparam logic REG_MARK = 1'b0;
	localparam logic REG_MERGE = 1'b1;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	localparam logic [RAD_W-1:0] MARK_RESET = RAD_W'(16384);
	localparam logic [RAD_W-1:0] MERGE_RESET = RAD_W'(32768);

	typedef struct packed {
		logic load;
		logic issue;
		logic capture;
		logic commit;
	} dmt_cmd_t;

	typedef struct packed {
		logic issue_done;
		logic pipe_empty;
		logic hit;
		logic out_busy;
	} dmt_sts_t;

	// clamp a 33-bit signed sum into the 32-bit range
	function automatic logic signed [COORD_W-1:0] sat32(input logic [COORD_W:0] s);
		logic signed [COORD_W-1:0] r;
		if (s[COORD_W] != s[COORD_W-1])
			r = s[COORD_W] ? COORD_MIN : COORD_MAX;
		else
			r = s[COORD_W-1:0];
		return r;
	endfunction

	// floor((a + b) / 2)
	function automatic logic signed [COORD_W-1:0] midpoint(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		logic [COORD_W:0] s;
		s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
		return s[COORD_W:1];
	endfunction

endpackage

// ===== design/dmt_ctrl.sv =====
module dmt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dmt_pkg::dmt_sts_t sts,
	output dmt_pkg::dmt_cmd_t cmd
);
	import dmt_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid)
					state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.issue = !sts.issue_done && !sts.hit;
				cmd.capture = sts.hit;
				if (sts.hit || (sts.issue_done && sts.pipe_empty))
					state_d = S_COMMIT;
			end
			S_COMMIT: begin
				// hold until the output register is free
				cmd.commit = !sts.out_busy;
				if (!sts.out_busy)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== design/dmt_datapath.sv =====
module dmt_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dmt_pkg::dmt_cmd_t                    cmd,
	output dmt_pkg::dmt_sts_t                    sts,
	input  logic signed [dmt_pkg::COORD_W-1:0]   detect_x,
	input  logic signed [dmt_pkg::COORD_W-1:0]   detect_y,
	input  logic [dmt_pkg::RAD_W-1:0]            mark_radius,
	input  logic [dmt_pkg::RAD_W-1:0]            merge_radius,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic [1:0]                           action,
	output logic [dmt_pkg::IDX_W-1:0]            slot,
	output logic signed [dmt_pkg::COORD_W-1:0]   entry_x,
	output logic signed [dmt_pkg::COORD_W-1:0]   entry_y,
	output logic signed [dmt_pkg::COORD_W-1:0]   box_min_x,
	output logic signed [dmt_pkg::COORD_W-1:0]   box_min_y,
	output logic signed [dmt_pkg::COORD_W-1:0]   box_max_x,
	output logic signed [dmt_pkg::COORD_W-1:0]   box_max_y,
	output logic [dmt_pkg::CNT_W-1:0]            entry_count
);
	import dmt_pkg::*;

	// point table: {y, x}
	logic [2*COORD_W-1:0] mem_q [TABLE_DEPTH];

	logic signed [COORD_W-1:0] x_q, y_q;
	logic [SQ_W-1:0] rr_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] issue_idx_q;
	logic signed [COORD_W-1:0] low_x_q, low_y_q, high_x_q, high_y_q;

	logic v_s1, v_s2, v_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic [2*COORD_W-1:0] rdata_s1;
	logic signed [COORD_W-1:0] px_s2, py_s2, px_s3, py_s3;
	logic [RAD_W-1:0] dx_s2, dy_s2;
	logic near_s2, near_s3;
	logic [SQ_W-1:0] sqx_s3, sqy_s3;

	logic match_q;
	logic [IDX_W-1:0] match_idx_q;
	logic signed [COORD_W-1:0] mpx_q, mpy_q;

	logic out_valid_q;
	logic [1:0] action_q;
	logic [IDX_W-1:0] slot_q;
	logic signed [COORD_W-1:0] entry_x_q, entry_y_q;
	logic signed [COORD_W-1:0] bmin_x_q, bmin_y_q, bmax_x_q, bmax_y_q;
	logic [CNT_W-1:0] count_out_q;

	// box candidates from the incoming point
	logic signed [COORD_W-1:0] lo_x_c, lo_y_c, hi_x_c, hi_y_c;
	logic [COORD_W:0] rad_ext;
	assign rad_ext = {{(COORD_W+1-RAD_W){1'b0}}, mark_radius};
	assign lo_x_c = sat32({detect_x[COORD_W-1], detect_x} - rad_ext);
	assign lo_y_c = sat32({detect_y[COORD_W-1], detect_y} - rad_ext);
	assign hi_x_c = sat32({detect_x[COORD_W-1], detect_x} + rad_ext);
	assign hi_y_c = sat32({detect_y[COORD_W-1], detect_y} + rad_ext);

	// stage 2 distance terms
	logic [COORD_W:0] diff_x, diff_y, abs_x, abs_y, r_ext;
	logic signed [COORD_W-1:0] rd_x, rd_y;
	assign rd_x = rdata_s1[COORD_W-1:0];
	assign rd_y = rdata_s1[2*COORD_W-1:COORD_W];
	assign diff_x = {rd_x[COORD_W-1], rd_x} - {x_q[COORD_W-1], x_q};
	assign diff_y = {rd_y[COORD_W-1], rd_y} - {y_q[COORD_W-1], y_q};
	assign abs_x = diff_x[COORD_W] ? (~diff_x + 1'b1) : diff_x;
	assign abs_y = diff_y[COORD_W] ? (~diff_y + 1'b1) : diff_y;
	assign r_ext = {{(COORD_W+1-RAD_W){1'b0}}, merge_radius};

	logic [SQ_W:0] dist_sq;
	logic hit;
	assign dist_sq = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	assign hit = v_s3 && near_s3 && (dist_sq <= {1'b0, rr_q});

	// commit decision
	logic full;
	logic wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic signed [COORD_W-1:0] wr_x, wr_y;
	logic [1:0] act_c;
	assign full = (count_q == CNT_W'(TABLE_DEPTH));

	always_comb begin
		wr_en = 1'b0;
		wr_idx = '0;
		wr_x = '0;
		wr_y = '0;
		act_c = ACT_DROP;
		if (match_q) begin
			wr_en = cmd.commit;
			wr_idx = match_idx_q;
			wr_x = midpoint(mpx_q, x_q);
			wr_y = midpoint(mpy_q, y_q);
			act_c = ACT_MERGE;
		end else if (!full) begin
			wr_en = cmd.commit;
			wr_idx = count_q[IDX_W-1:0];
			wr_x = x_q;
			wr_y = y_q;
			act_c = ACT_APPEND;
		end
	end

	// table and read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_idx] <= {wr_y, wr_x};
		rdata_s1 <= mem_q[issue_idx_q[IDX_W-1:0]];
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= detect_x;
			y_q <= detect_y;
			rr_q <= merge_radius * merge_radius;
		end
		idx_s1 <= issue_idx_q[IDX_W-1:0];
		idx_s2 <= idx_s1;
		px_s2 <= rd_x;
		py_s2 <= rd_y;
		dx_s2 <= abs_x[RAD_W-1:0];
		dy_s2 <= abs_y[RAD_W-1:0];
		near_s2 <= (abs_x <= r_ext) && (abs_y <= r_ext);
		idx_s3 <= idx_s2;
		px_s3 <= px_s2;
		py_s3 <= py_s2;
		near_s3 <= near_s2;
		sqx_s3 <= dx_s2 * dx_s2;
		sqy_s3 <= dy_s2 * dy_s2;
		if (cmd.capture) begin
			match_idx_q <= idx_s3;
			mpx_q <= px_s3;
			mpy_q <= py_s3;
		end
		if (cmd.commit) begin
			action_q <= act_c;
			slot_q <= wr_en ? wr_idx : '0;
			entry_x_q <= wr_x;
			entry_y_q <= wr_y;
			bmin_x_q <= low_x_q;
			bmin_y_q <= low_y_q;
			bmax_x_q <= high_x_q;
			bmax_y_q <= high_y_q;
			count_out_q <= (!match_q && !full) ? count_q + 1'b1 : count_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			issue_idx_q <= '0;
			low_x_q <= COORD_MAX;
			low_y_q <= COORD_MAX;
			high_x_q <= COORD_MIN;
			high_y_q <= COORD_MIN;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			match_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				issue_idx_q <= '0;
				match_q <= 1'b0;
				v_s1 <= 1'b0;
				v_s2 <= 1'b0;
				v_s3 <= 1'b0;
				if (lo_x_c < low_x_q) low_x_q <= lo_x_c;
				if (lo_y_c < low_y_q) low_y_q <= lo_y_c;
				if (hi_x_c > high_x_q) high_x_q <= hi_x_c;
				if (hi_y_c > high_y_q) high_y_q <= hi_y_c;
			end else begin
				if (cmd.issue)
					issue_idx_q <= issue_idx_q + 1'b1;
				v_s1 <= cmd.issue;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				if (cmd.capture)
					match_q <= 1'b1;
			end
			if (cmd.commit && !match_q && !full)
				count_q <= count_q + 1'b1;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign sts.issue_done = (issue_idx_q == count_q);
	assign sts.pipe_empty = !v_s1 && !v_s2 && !v_s3;
	assign sts.hit = hit;
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign action = action_q;
	assign slot = slot_q;
	assign entry_x = entry_x_q;
	assign entry_y = entry_y_q;
	assign box_min_x = bmin_x_q;
	assign box_min_y = bmin_y_q;
	assign box_max_x = bmax_x_q;
	assign box_max_y = bmax_y_q;
	assign entry_count = count_out_q;

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> issue_idx_q < count_q)
		else $error("read issued past the stored count");

	a_append_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !match_q && !full) |=> count_q == $past(count_q) + 1'b1)
		else $error("append did not advance the count");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q && count_out_q == count_q)
		else $error("commit did not publish the item");

	a_load_flush: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !v_s1 && !v_s2 && !v_s3 && !match_q && issue_idx_q == '0)
		else $error("scan state not flushed on load");

endmodule

// ===== design/detection_merge_table_top.sv =====
// Detection merge table.
// Input channel: detect_x/detect_y (signed Q16.16) with in_valid/in_ready.
// Output channel: one result item per input item, with out_valid/out_ready:
//   action, slot, entry_x/entry_y, the bounding box and entry_count.
// Config: APB-style port, mark_radius at address 0, merge_radius at 4
//   (24 bits each, only bit 2 of paddr selects); write only while idle.
// Each item first widens the box by +/- mark_radius (saturated), then reads
// the stored points one per cycle through a 3-stage compare pipeline
// (abs difference, square, sum and compare). The first match is replaced by
// the midpoint; otherwise the point is appended, or dropped when full.
// The scan time grows with the number of stored points, or with the slot of
// a match, and is set by the single read port of the table. One item is in
// work at a time; the next is taken the cycle after the result is loaded.
// The result waits in an output register, so a stalled receiver only holds
// off the commit of the following item, not its acceptance or scan.
// Reset clears the count, sets the box to empty (min at the most positive
// value, max at the most negative) and restores the radius defaults.
module detection_merge_table_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [dmt_pkg::ADDR_W-1:0]          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [dmt_pkg::COORD_W-1:0]  detect_x,
	input  logic signed [dmt_pkg::COORD_W-1:0]  detect_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          action,
	output logic [dmt_pkg::IDX_W-1:0]           slot,
	output logic signed [dmt_pkg::COORD_W-1:0]  entry_x,
	output logic signed [dmt_pkg::COORD_W-1:0]  entry_y,
	output logic signed [dmt_pkg::COORD_W-1:0]  box_min_x,
	output logic signed [dmt_pkg::COORD_W-1:0]  box_min_y,
	output logic signed [dmt_pkg::COORD_W-1:0]  box_max_x,
	output logic signed [dmt_pkg::COORD_W-1:0]  box_max_y,
	output logic [dmt_pkg::CNT_W-1:0]           entry_count
);
	import dmt_pkg::*;

	logic [RAD_W-1:0] mark_radius_q;
	logic [RAD_W-1:0] merge_radius_q;
	logic cfg_wr;
	dmt_cmd_t cmd;
	dmt_sts_t sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// register file: bit 2 of the address picks the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_radius_q <= MARK_RESET;
			merge_radius_q <= MERGE_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MARK: mark_radius_q <= pwdata[RAD_W-1:0];
				REG_MERGE: merge_radius_q <= pwdata[RAD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MARK: prdata = {{(32-RAD_W){1'b0}}, mark_radius_q};
			REG_MERGE: prdata = {{(32-RAD_W){1'b0}}, merge_radius_q};
			default: prdata = '0;
		endcase
	end

	dmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dmt_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.detect_x     (detect_x),
		.detect_y     (detect_y),
		.mark_radius  (mark_radius_q),
		.merge_radius (merge_radius_q),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.action       (action),
		.slot         (slot),
		.entry_x      (entry_x),
		.entry_y      (entry_y),
		.box_min_x    (box_min_x),
		.box_min_y    (box_min_y),
		.box_max_x    (box_max_x),
		.box_max_y    (box_max_y),
		.entry_count  (entry_count)
	);

endmodule

// ===== tb/sv/merge_table_checker.sv =====
module merge_table_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic                                pready,
	input  logic [dmt_pkg::ADDR_W-1:0]          paddr,
	input  logic [31:0]                         pwdata,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic signed [dmt_pkg::COORD_W-1:0]  detect_x,
	input  logic signed [dmt_pkg::COORD_W-1:0]  detect_y,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [1:0]                          action,
	input  logic [dmt_pkg::IDX_W-1:0]           slot,
	input  logic signed [dmt_pkg::COORD_W-1:0]  entry_x,
	input  logic signed [dmt_pkg::COORD_W-1:0]  entry_y,
	input  logic signed [dmt_pkg::COORD_W-1:0]  box_min_x,
	input  logic signed [dmt_pkg::COORD_W-1:0]  box_min_y,
	input  logic signed [dmt_pkg::COORD_W-1:0]  box_max_x,
	input  logic signed [dmt_pkg::COORD_W-1:0]  box_max_y,
	input  logic [dmt_pkg::CNT_W-1:0]           entry_count,
	output int                                  fail_count,
	output int                                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import dmt_pkg::*;

	typedef struct packed {
		logic [1:0]                act;
		logic [IDX_W-1:0]          idx;
		logic signed [COORD_W-1:0] ex;
		logic signed [COORD_W-1:0] ey;
		logic signed [COORD_W-1:0] lx;
		logic signed [COORD_W-1:0] ly;
		logic signed [COORD_W-1:0] hx;
		logic signed [COORD_W-1:0] hy;
		logic [CNT_W-1:0]          cnt;
	} outcome_t;

	logic [RAD_W-1:0]          mark_r;
	logic [RAD_W-1:0]          merge_r;
	logic signed [COORD_W-1:0] pts_x [TABLE_DEPTH];
	logic signed [COORD_W-1:0] pts_y [TABLE_DEPTH];
	int                        n_pts;
	logic signed [COORD_W-1:0] lo_x, lo_y, hi_x, hi_y;
	outcome_t                  outcome_q [$];

	function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
		if (v > longint'(COORD_MAX))
			return COORD_MAX;
		if (v < longint'(COORD_MIN))
			return COORD_MIN;
		return v[COORD_W-1:0];
	endfunction

	function automatic logic signed [COORD_W-1:0] halfway(
		logic signed [COORD_W-1:0] a,
		logic signed [COORD_W-1:0] b
	);
		longint s;
		s = (longint'(a) + longint'(b)) >>> 1;
		return s[COORD_W-1:0];
	endfunction

	function automatic longint unsigned axis_gap(
		logic signed [COORD_W-1:0] a,
		logic signed [COORD_W-1:0] b
	);
		longint d;
		d = longint'(a) - longint'(b);
		return (d < 0) ? -d : d;
	endfunction

	function automatic bit within_merge(int i, logic signed [COORD_W-1:0] x,
		logic signed [COORD_W-1:0] y);
		longint unsigned r, dx, dy;
		r = merge_r;
		dx = axis_gap(pts_x[i], x);
		dy = axis_gap(pts_y[i], y);
		if (dx > r || dy > r)
			return 1'b0;
		return (dx * dx + dy * dy) <= (r * r);
	endfunction

	// widen the box, then merge into the first close point, append, or drop when full
	function automatic outcome_t merge_point(logic signed [COORD_W-1:0] x,
		logic signed [COORD_W-1:0] y);
		outcome_t                  o;
		longint                    m;
		logic signed [COORD_W-1:0] t;
		int                        hit;
		int                        i;
		m = longint'(mark_r);
		t = clamp_coord(longint'(x) - m);
		if (t < lo_x) lo_x = t;
		t = clamp_coord(longint'(y) - m);
		if (t < lo_y) lo_y = t;
		t = clamp_coord(longint'(x) + m);
		if (t > hi_x) hi_x = t;
		t = clamp_coord(longint'(y) + m);
		if (t > hi_y) hi_y = t;

		hit = -1;
		for (i = 0; i < n_pts; i++)
			if (hit < 0 && within_merge(i, x, y))
				hit = i;

		o = '0;
		o.act = ACT_DROP;
		if (hit >= 0) begin
			pts_x[hit] = halfway(pts_x[hit], x);
			pts_y[hit] = halfway(pts_y[hit], y);
			o.act = ACT_MERGE;
			o.idx = IDX_W'(hit);
			o.ex = pts_x[hit];
			o.ey = pts_y[hit];
		end else if (n_pts < TABLE_DEPTH) begin
			pts_x[n_pts] = x;
			pts_y[n_pts] = y;
			o.act = ACT_APPEND;
			o.idx = IDX_W'(n_pts);
			o.ex = x;
			o.ey = y;
			n_pts++;
		end
		o.lx = lo_x;
		o.ly = lo_y;
		o.hx = hi_x;
		o.hy = hi_y;
		o.cnt = CNT_W'(n_pts);
		return o;
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] %s", $realtime, msg);
	endtask

	task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
		if (got !== want)
			note_failure($sformatf("%s mismatch: expected %08h, got %08h", fname, want, got));
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		if (!arst_n) begin
			mark_r = MARK_RESET;
			merge_r = MERGE_RESET;
			n_pts = 0;
			lo_x = COORD_MAX;
			lo_y = COORD_MAX;
			hi_x = COORD_MIN;
			hi_y = COORD_MIN;
			outcome_q.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_MERGE)
					merge_r = pwdata[RAD_W-1:0];
				else
					mark_r = pwdata[RAD_W-1:0];
			end
			if (out_valid && out_ready) begin
				if (outcome_q.size() == 0) begin
					note_failure("result item with nothing outstanding");
				end else begin
					want = outcome_q.pop_front();
					check_field("action", 32'(want.act), 32'(action));
					check_field("slot", 32'(want.idx), 32'(slot));
					check_field("entry_x", want.ex, entry_x);
					check_field("entry_y", want.ey, entry_y);
					check_field("box_min_x", want.lx, box_min_x);
					check_field("box_min_y", want.ly, box_min_y);
					check_field("box_max_x", want.hx, box_max_x);
					check_field("box_max_y", want.hy, box_max_y);
					check_field("entry_count", 32'(want.cnt), 32'(entry_count));
				end
			end
			if (in_valid && in_ready)
				outcome_q.insert(outcome_q.size(), merge_point(detect_x, detect_y));
		end
		outstanding = outcome_q.size();
	end

endmodule

// ===== tb/sv/tb_detection_merge_table_top.sv =====
module tb_detection_merge_table_top;
	timeunit 1ns;
	timeprecision 1ps;
	import dmt_pkg::*;

	// slowest run is far below this: ~420 items in all
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 50;
	localparam int NUM_PHASES = 8;

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [ADDR_W-1:0]          paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [COORD_W-1:0]  detect_x;
	logic signed [COORD_W-1:0]  detect_y;
	logic                       out_valid;
	logic                       out_ready;
	logic [1:0]                 action;
	logic [IDX_W-1:0]           slot;
	logic signed [COORD_W-1:0]  entry_x;
	logic signed [COORD_W-1:0]  entry_y;
	logic signed [COORD_W-1:0]  box_min_x;
	logic signed [COORD_W-1:0]  box_min_y;
	logic signed [COORD_W-1:0]  box_max_x;
	logic signed [COORD_W-1:0]  box_max_y;
	logic [CNT_W-1:0]           entry_count;

	int                         fail_count;
	int                         outstanding;
	int                         cycle_cnt = 0;

	// no idling on either side while set
	bit                         steady = 1'b0;

	// merge radius as last written, used to aim points at the merge boundary
	int                         merge_now = int'(MERGE_RESET);

	// points sent so far (up to one table's worth); random items aim near them
	logic signed [COORD_W-1:0]  seen_x [$];
	logic signed [COORD_W-1:0]  seen_y [$];

	detection_merge_table_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.detect_x    (detect_x),
		.detect_y    (detect_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.action      (action),
		.slot        (slot),
		.entry_x     (entry_x),
		.entry_y     (entry_y),
		.box_min_x   (box_min_x),
		.box_min_y   (box_min_y),
		.box_max_x   (box_max_x),
		.box_max_y   (box_max_y),
		.entry_count (entry_count)
	);

	merge_table_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.detect_x    (detect_x),
		.detect_y    (detect_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.action      (action),
		.slot        (slot),
		.entry_x     (entry_x),
		.entry_y     (entry_y),
		.box_min_x   (box_min_x),
		.box_min_y   (box_min_y),
		.box_max_x   (box_max_x),
		.box_max_y   (box_max_y),
		.entry_count (entry_count),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// hard stop in case a handshake never completes
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// receiver: hold ready high for a while, then stall for a random gap
	initial begin : sink
		int n;
		out_ready = 1'b0;
		@(negedge clk);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(negedge clk);
		end
	end

	// Present one item after an optional gap and hold it until accepted.
	// Called and returns at a falling edge; valid stays high on return so a
	// back-to-back item just swaps the payload.
	task automatic send_item(input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		detect_x <= x;
		detect_y <= y;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (seen_x.size() < TABLE_DEPTH) begin
			seen_x.insert(seen_x.size(), x);
			seen_y.insert(seen_y.size(), y);
		end
	endtask

	// register write: setup phase, then access phase
	task automatic write_reg(input logic reg_sel, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (reg_sel == REG_MERGE)
			merge_now = int'(value[RAD_W-1:0]);
	endtask

	// drop valid and wait until every result item has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	// Random point: mostly aimed at an earlier point (inside, on or just past
	// the merge circle), the rest anywhere, near the origin or near the rails.
	task automatic pick_point(output logic signed [COORD_W-1:0] x,
		output logic signed [COORD_W-1:0] y);
		int kind, k, r, dx, dy, d;
		kind = $urandom_range(0, 99);
		r = merge_now;
		if (seen_x.size() > 0 && kind < 55) begin
			k = $urandom_range(0, seen_x.size() - 1);
			dx = 0;
			dy = 0;
			case ($urandom_range(0, 3))
				0: begin
					dx = int'($urandom_range(0, 2 * r + 4)) - (r + 2);
					dy = int'($urandom_range(0, 2 * r + 4)) - (r + 2);
				end
				1: begin
					// on the radius along one axis, or one past it
					d = r + int'($urandom_range(0, 1));
					if ($urandom_range(0, 1))
						d = -d;
					if ($urandom_range(0, 1))
						dx = d;
					else
						dy = d;
				end
				2: begin
					// on the diagonal, around r / sqrt(2)
					d = int'((longint'(r) * 46341) >>> 16) + int'($urandom_range(0, 2)) - 1;
					dx = $urandom_range(0, 1) ? d : -d;
					dy = $urandom_range(0, 1) ? d : -d;
				end
				default: ;
			endcase
			x = seen_x[k] + dx;
			y = seen_y[k] + dy;
		end else if (kind < 75) begin
			x = $urandom();
			y = $urandom();
		end else if (kind < 92) begin
			x = int'($urandom_range(0, 1 << 23)) - (1 << 22);
			y = int'($urandom_range(0, 1 << 23)) - (1 << 22);
		end else begin
			x = $urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 'hFFFF)
				: COORD_MIN + $urandom_range(0, 'hFFFF);
			y = $urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 'hFFFF)
				: COORD_MIN + $urandom_range(0, 'hFFFF);
		end
	endtask

	initial begin : stimulus
		logic signed [COORD_W-1:0] px, py;
		logic [31:0]               mark_w, merge_w;
		int                        ph, n;

		// known values on every input from time zero
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		detect_x = '0;
		detect_y = '0;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed part at the reset radii (mark 0.25, merge 0.5).
		// Empty table: first point always appends.
		send_item(0, 0);
		// exactly on the merge radius along x: merges into slot 0
		send_item(32768, 0);
		// one past the radius from the merged point: appends
		send_item(16384 + 32769, 0);
		// fresh point, then a diagonal just outside the circle and one inside
		send_item(32'sh0010_0000, 32'sh0010_0000);
		send_item(32'sh0010_0000 + 23171, 32'sh0010_0000 + 23171);
		send_item(32'sh0010_0000 + 23170, 32'sh0010_0000 - 23170);
		// rails: box bounds saturate, axis differences exceed 32 bits
		send_item(COORD_MAX, COORD_MAX);
		send_item(COORD_MIN, COORD_MIN);
		send_item(COORD_MAX, COORD_MIN);
		send_item(COORD_MIN, COORD_MAX);
		// exact repeat of a stored point merges onto itself
		send_item(COORD_MAX, COORD_MAX);
		// midpoint with negative odd sums rounds down
		send_item(-1000001, 7);
		send_item(-1000000, 8);
		send_item(5000000, -3);
		send_item(5000001, -2);
		// alternating bit patterns on both fields
		send_item(32'sh5555_5555, 32'shAAAA_AAAA);
		send_item(32'shAAAA_AAAA, 32'sh5555_5555);
		drain();

		// Random phases, each at its own radius setting. Merge radius zero
		// first so the table fills and later phases see it full.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					mark_w = 0;
					merge_w = 0;
				end
				1: begin
					mark_w = 8388608;
					merge_w = 8388608;
				end
				2: begin
					// above the documented range, upper byte ignored
					mark_w = 32'hFFFF_FFFF;
					merge_w = 32'hFFFF_FFFF;
				end
				5: begin
					mark_w = $urandom();
					merge_w = $urandom();
				end
				default: begin
					mark_w = $urandom_range(0, 1 << 20);
					merge_w = $urandom_range(0, 1 << 18);
				end
			endcase
			write_reg(REG_MARK, mark_w);
			write_reg(REG_MERGE, merge_w);
			steady = (ph == 0 || ph == 4);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				pick_point(px, py);
				send_item(px, py);
			end
			drain();
		end

		// let any stray result item show up before the verdict
		repeat (80) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/dmt_pkg.sv
design/dmt_ctrl.sv
design/dmt_datapath.sv
design/detection_merge_table_top.sv
tb/sv/merge_table_checker.sv
tb/sv/tb_detection_merge_table_top.sv
